// File: sv/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg: shared types for the byte insertion sorter
// Data word type and the control group that is broadcast to the cell chain.
// ----------------------------------------------------------------------------
package bis_pkg;

  localparam int DataWidth = 8;

  typedef logic [DataWidth-1:0] data_t;

  // Chain-wide command, one per cycle
  typedef struct packed {
    logic ins;    // insert the broadcast byte
    logic shift;  // move every word one place toward cell 0
  } bis_ctrl_t;

endpackage

// File: sv/bis_cell.sv
// ----------------------------------------------------------------------------
// bis_cell: one slot of the insertion chain
// Holds one byte and a valid bit; inserts by comparison with the broadcast
// byte or shifts toward cell 0 while the run drains.
// ----------------------------------------------------------------------------
module bis_cell
  import bis_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  bis_ctrl_t ctrl,
  input  data_t     ins_byte,
  input  data_t     left_value,
  input  logic      left_valid,
  input  logic      left_gt,
  input  data_t     right_value,
  input  logic      right_valid,
  output data_t     value,
  output logic      valid,
  output logic      gt
);

  data_t value_r, value_nxt;
  logic  valid_r, valid_nxt;

  // empty slots count as larger than any byte; equal bytes stay put
  assign gt = !valid_r || (value_r > ins_byte);

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctrl.shift) begin
      value_nxt = right_value;
      valid_nxt = right_valid;
    end else if (ctrl.ins) begin
      valid_nxt = valid_r | left_valid;
      if (gt) begin
        value_nxt = left_gt ? left_value : ins_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign value = value_r;
  assign valid = valid_r;

endmodule

// File: sv/byte_insertion_sorter_top.sv
// ----------------------------------------------------------------------------
// byte_insertion_sorter_top: stable insertion sorter over a cell chain
// Collects a run of bytes in ascending order, then streams it out.
// ----------------------------------------------------------------------------
// Fill: one input word per cycle while not draining; each byte lands in its
// sorted slot at once. Drain: after the word flagged last, the chain shifts
// one word per cycle into the output register while that register is free or
// being emptied; the last input sets the draining flag, then cell 0 loads the
// output register. Input is stalled while the chain drains.
// Reset (synchronous, rst_n low) empties the chain and clears the drop flag.
// ----------------------------------------------------------------------------
module byte_insertion_sorter_top
  import bis_pkg::*;
#(
  parameter int MAX_ITEMS = 64
) (
  input  logic  clk,
  input  logic  rst_n,
  // input words
  input  logic  in_valid,
  output logic  in_stall,
  input  data_t in_data_byte,
  input  logic  in_last_item,
  // result words
  output logic  out_valid,
  input  logic  out_stall,
  output data_t out_sorted_byte,
  output logic  out_last_out,
  output logic  out_overflow
);

  // chain taps, cell 0 holds the smallest byte
  data_t     cell_value [MAX_ITEMS];
  logic      cell_valid [MAX_ITEMS];
  logic      cell_gt    [MAX_ITEMS];
  bis_ctrl_t ctrl;

  logic  draining_r, draining_nxt;
  logic  dropped_r, dropped_nxt;
  logic  out_valid_r, out_valid_nxt;
  data_t out_byte_r;
  logic  out_last_r;
  logic  out_ovf_r;

  logic  in_accept;
  logic  full;
  logic  load;      // move cell 0 into the output register

  assign full      = cell_valid[MAX_ITEMS-1];
  assign in_stall  = draining_r;
  assign in_accept = in_valid && !draining_r;

  // output register free or being emptied this cycle
  assign load = draining_r && (!out_valid_r || !out_stall);

  assign ctrl.ins   = in_accept && !full;
  assign ctrl.shift = load;

  // ---- cell chain ----
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    data_t l_value, r_value;
    logic  l_valid, l_gt, r_valid;

    if (i == 0) begin : g_head
      // head cell always takes the new byte when its own byte is larger or it is empty
      assign l_value = '0;
      assign l_valid = 1'b1;
      assign l_gt    = 1'b0;
    end else begin : g_body
      assign l_value = cell_value[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_gt    = cell_gt[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign r_value = '0;
      assign r_valid = 1'b0;
    end else begin : g_mid
      assign r_value = cell_value[i+1];
      assign r_valid = cell_valid[i+1];
    end

    bis_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .ins_byte    (in_data_byte),
      .left_value  (l_value),
      .left_valid  (l_valid),
      .left_gt     (l_gt),
      .right_value (r_value),
      .right_valid (r_valid),
      .value       (cell_value[i]),
      .valid       (cell_valid[i]),
      .gt          (cell_gt[i])
    );
  end

  // ---- run control ----
  always_comb begin
    draining_nxt = draining_r;
    dropped_nxt  = dropped_r;
    if (in_accept) begin
      // byte arriving at a full chain is lost; remember it for the run
      if (full) begin
        dropped_nxt = 1'b1;
      end
      if (in_last_item) begin
        draining_nxt = 1'b1;
      end
    end
    if (load && !cell_valid[1]) begin
      // final word leaves the chain: ready for the next run
      draining_nxt = 1'b0;
      dropped_nxt  = 1'b0;
    end
  end

  // ---- output register ----
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= cell_value[0];
      out_last_r <= !cell_valid[1];
      out_ovf_r  <= dropped_r;
    end
    if (!rst_n) begin
      draining_r  <= 1'b0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      draining_r  <= draining_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sorted_byte = out_byte_r;
  assign out_last_out    = out_last_r;
  assign out_overflow    = out_ovf_r;

endmodule

// File: dv/byte_insertion_sorter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_insertion_sorter_top_tb: self-checking bench for the byte sorter
// Runs of bytes go in; a scoreboard keeps its own sorted copy of each run and
// checks every streamed result word against it. Traffic runs in four phases
// of source gaps and sink stalls.
// ----------------------------------------------------------------------------
module byte_insertion_sorter_top_tb;
  import bis_pkg::*;

  localparam int Capacity    = 64;
  localparam int RandomItems = 470;
  localparam int NumPhases   = 4;
  localparam int DrainCycles = 8;
  // Worst case is far below this: ~470 input words plus at most as many results,
  // each held up by random gaps and stalls.
  localparam int CycleLimit  = 400000;

  // One result word as the block should present it
  typedef struct {
    data_t value;
    logic  is_last;
    logic  ovf;
  } sorted_word_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps the run sorted as it arrives and queues the words that
  // the flagged last byte releases.
  // --------------------------------------------------------------------------
  class run_order_board;
    data_t        run_bytes[$];  // current run, ascending
    bit           run_dropped;   // a byte of this run found the store full
    sorted_word_t due_words[$];  // results not yet seen, oldest first
    int           misses = 0;

    task flag(string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      misses++;
    endtask

    // Stable insert: the new byte goes above every stored byte that is not
    // greater, so equal bytes stay in arrival order.
    function void take_byte(data_t value, logic is_last);
      int           pos;
      sorted_word_t w;
      if (run_bytes.size() < Capacity) begin
        pos = run_bytes.size();
        while (pos > 0 && run_bytes[pos-1] > value) pos--;
        run_bytes.insert(pos, value);
      end else begin
        run_dropped = 1'b1;
      end
      if (is_last) begin
        foreach (run_bytes[k]) begin
          w.value   = run_bytes[k];
          w.is_last = (k == run_bytes.size() - 1);
          w.ovf     = run_dropped;
          due_words.push_back(w);
        end
        run_bytes.delete();
        run_dropped = 1'b0;
      end
    endfunction

    task check_word(data_t value, logic is_last, logic ovf);
      sorted_word_t want;
      if (due_words.size() == 0) begin
        flag($sformatf("unexpected word byte=%02h last=%b ovf=%b", value, is_last, ovf));
        return;
      end
      want = due_words.pop_front();
      if (value !== want.value)
        flag($sformatf("sorted_byte got %02h want %02h", value, want.value));
      if (is_last !== want.is_last)
        flag($sformatf("last_out got %b want %b (byte %02h)", is_last, want.is_last,
                       want.value));
      if (ovf !== want.ovf)
        flag($sformatf("overflow got %b want %b (byte %02h)", ovf, want.ovf, want.value));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  data_t in_data_byte = '0;
  logic  in_last_item = 1'b0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  data_t out_sorted_byte;
  logic  out_last_out;
  logic  out_overflow;

  initial begin
    forever #10 clk = ~clk;
  end

  byte_insertion_sorter_top #(
    .MAX_ITEMS(Capacity)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_last_item   (in_last_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sorted_byte(out_sorted_byte),
    .out_last_out   (out_last_out),
    .out_overflow   (out_overflow)
  );

  run_order_board board = new;

  // Traffic shape per phase, in percent:
  //   0: no gaps, no stalls  1: source idles  2: sink stalls  3: both
  int phase = 0;
  int gap_pct[NumPhases]   = '{0, 62, 0, 33};
  int stall_pct[NumPhases] = '{0, 0, 62, 33};
  int words_sent = 0;
  int cycles = 0;
  data_t run_q[$];

  // Watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("byte_insertion_sorter_top regression: fail");
      $finish;
    end
  end

  // Sink: stall decided at each falling edge, so it is settled at the next
  // rising edge where the result word is sampled.
  initial begin
    forever begin
      @(negedge clk);
      out_stall = ($urandom_range(99) < stall_pct[phase]);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_word(out_sorted_byte, out_last_out, out_overflow);
  end

  // --------------------------------------------------------------------------
  // Source tasks. Entered and left at a falling edge. Valid stays high from
  // one word to the next unless a gap is drawn; each word is held while in_stall is high.
  // --------------------------------------------------------------------------
  task send_word(data_t value, logic is_last);
    while ($urandom_range(99) < gap_pct[phase]) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_data_byte = value;
    in_last_item = is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_byte(value, is_last);
    words_sent++;
    @(negedge clk);
  endtask

  // Sends run_q, flagging its final byte as last
  task send_run();
    foreach (run_q[k]) send_word(run_q[k], k == run_q.size() - 1);
  endtask

  // Random run: mostly short, some single bytes, a few near or past capacity
  // so the drop path (including a dropped last byte) is hit.
  task random_run();
    int    len;
    int    pick;
    int    style;
    data_t base;
    pick  = $urandom_range(99);
    style = $urandom_range(2);
    base  = data_t'($urandom);
    if (pick < 8)       len = $urandom_range(Capacity - 1, Capacity + 8);
    else if (pick < 18) len = 1;
    else                len = $urandom_range(2, 20);
    run_q.delete();
    repeat (len) begin
      case (style)
        0: run_q.push_back(data_t'($urandom));
        // narrow spread: many equal bytes
        1: run_q.push_back(base + data_t'($urandom_range(3)));
        // extremes and the 127/128 boundary where a signed compare would break
        default: begin
          case ($urandom_range(3))
            0: run_q.push_back(8'h00);
            1: run_q.push_back(8'hFF);
            2: run_q.push_back(8'h7F);
            default: run_q.push_back(8'h80);
          endcase
        end
      endcase
    end
    send_run();
  endtask

  task wait_drained();
    in_valid = 1'b0;
    while (board.due_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed runs: single byte at each extreme, signed/unsigned boundary,
    // duplicates, reverse and in-order arrival.
    run_q = '{8'h00};
    send_run();
    run_q = '{8'hFF};
    send_run();
    run_q = '{8'h80, 8'h7F, 8'hFF, 8'h00, 8'h01, 8'hFE};
    send_run();
    run_q = '{8'h55, 8'h55, 8'hAA, 8'h55};
    send_run();
    run_q = '{8'h90, 8'h70, 8'h30, 8'h10, 8'h01};
    send_run();
    run_q = '{8'h02, 8'h20, 8'h40, 8'h81, 8'hF0};
    send_run();

    // Random runs, a quarter of the budget per traffic phase; each phase
    // finishes its run and drains before the shape changes.
    for (int p = 0; p < NumPhases; p++) begin
      phase = p;
      words_sent = 0;
      while (words_sent < RandomItems / NumPhases) random_run();
      wait_drained();
    end

    if (board.misses == 0) begin
      $display("byte_insertion_sorter_top regression: pass");
    end else begin
      $display("byte_insertion_sorter_top regression: fail");
    end
    $finish;
  end

endmodule
